// ===== hdl/rfus_pkg.sv =====
// Shared types and constants for the request queue with user search.
package rfus_pkg;

  // Default sizes handed to the top level.
  localparam int unsigned DepthDef     = 64;
  localparam int unsigned UserWidthDef = 16;

  // Fixed field widths of the stream words.
  localparam int unsigned CmdW    = 2;
  localparam int unsigned UserInW = 16;
  localparam int unsigned OccW    = 7;

  // Command codes carried in the input tuser.
  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_EVICT  = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // One result word as it travels from the sequencer to the output register.
  typedef struct packed {
    logic            overflow;
    logic            not_empty;
    logic [OccW-1:0] occupancy;
    logic            found;
  } res_t;

endpackage

// ===== hdl/rfus_store.sv =====
// User number memory: one write port and one registered read port.
module rfus_store #(
  parameter int unsigned DEPTH      = rfus_pkg::DepthDef,
  parameter int unsigned USER_WIDTH = rfus_pkg::UserWidthDef,
  localparam int unsigned PtrW      = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [PtrW-1:0]       wr_addr_i,
  input  logic [USER_WIDTH-1:0] wr_data_i,
  input  logic                  rd_en_i,
  input  logic [PtrW-1:0]       rd_addr_i,
  output logic [USER_WIDTH-1:0] rd_data_o
);

  logic [USER_WIDTH-1:0] mem_q [DEPTH];
  logic [USER_WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/rfus_ctrl.sv =====
// Queue sequencer: pointers, entry count, command handling and the search scan.
module rfus_ctrl #(
  parameter int unsigned DEPTH      = rfus_pkg::DepthDef,
  parameter int unsigned USER_WIDTH = rfus_pkg::UserWidthDef,
  localparam int unsigned PtrW      = $clog2(DEPTH),
  localparam int unsigned CntW      = $clog2(DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Command side.
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  rfus_pkg::cmd_e               cmd_i,
  input  logic [USER_WIDTH-1:0]        user_i,
  // Result side.
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output rfus_pkg::res_t               res_o,
  // Memory side.
  output logic                         wr_en_o,
  output logic [PtrW-1:0]              wr_addr_o,
  output logic [USER_WIDTH-1:0]        wr_data_o,
  output logic                         rd_en_o,
  output logic [PtrW-1:0]              rd_addr_o,
  input  logic [USER_WIDTH-1:0]        rd_data_i
);

  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  rfus_pkg::state_e      state_q, state_d;
  logic [PtrW-1:0]       oldest_q, oldest_d;
  logic [PtrW-1:0]       newest_q, newest_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [PtrW-1:0]       scan_ptr_q, scan_ptr_d;
  logic [CntW-1:0]       left_q, left_d;
  logic                  rd_pend_q, rd_pend_d;
  logic [USER_WIDTH-1:0] key_q, key_d;
  logic                  found_q, found_d;
  logic                  over_q, over_d;
  logic                  match;

  function automatic logic [PtrW-1:0] wrap_next(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  assign match  = rd_pend_q && (rd_data_i == key_q);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rfus_pkg::ST_IDLE;
      oldest_q  <= '0;
      newest_q  <= '0;
      count_q   <= '0;
      left_q    <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      oldest_q  <= oldest_d;
      newest_q  <= newest_d;
      count_q   <= count_d;
      left_q    <= left_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  // Scan address, search key and pending result flags.
  always_ff @(posedge clk_i) begin
    scan_ptr_q <= scan_ptr_d;
    key_q      <= key_d;
    found_q    <= found_d;
    over_q     <= over_d;
  end

  // Next state, queue update and memory accesses.
  always_comb begin
    state_d    = state_q;
    oldest_d   = oldest_q;
    newest_d   = newest_q;
    count_d    = count_q;
    scan_ptr_d = scan_ptr_q;
    left_d     = left_q;
    rd_pend_d  = 1'b0;
    key_d      = key_q;
    found_d    = found_q;
    over_d     = over_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    wr_en_o    = 1'b0;
    rd_en_o    = 1'b0;

    unique case (state_q)
      rfus_pkg::ST_IDLE: begin
        // Ready is high throughout this state, so a valid word is taken at once.
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          found_d = 1'b0;
          over_d  = 1'b0;
          state_d = rfus_pkg::ST_DONE;
          unique case (cmd_i)
            rfus_pkg::CMD_INSERT: begin
              if (count_q == FullCnt) begin
                over_d = 1'b1;
              end else begin
                wr_en_o  = 1'b1;
                newest_d = wrap_next(newest_q);
                count_d  = count_q + CntW'(1);
              end
            end
            rfus_pkg::CMD_EVICT: begin
              if (count_q != '0) begin
                oldest_d = wrap_next(oldest_q);
                count_d  = count_q - CntW'(1);
              end
            end
            rfus_pkg::CMD_SEARCH: begin
              // An empty queue reports not found at once.
              if (count_q != '0) begin
                scan_ptr_d = oldest_q;
                left_d     = count_q;
                key_d      = user_i;
                state_d    = rfus_pkg::ST_SCAN;
              end
            end
            default: begin
              // The unused code leaves the queue as it is.
            end
          endcase
        end
      end
      rfus_pkg::ST_SCAN: begin
        // One entry is read a cycle, oldest first, and compared in the next cycle.
        priority if (match) begin
          found_d = 1'b1;
          state_d = rfus_pkg::ST_DONE;
        end else if (left_q == '0) begin
          state_d = rfus_pkg::ST_DONE;
        end else begin
          rd_en_o    = 1'b1;
          rd_pend_d  = 1'b1;
          scan_ptr_d = wrap_next(scan_ptr_q);
          left_d     = left_q - CntW'(1);
        end
      end
      rfus_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = rfus_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rfus_pkg::ST_IDLE;
      end
    endcase
  end

  assign wr_addr_o = newest_q;
  assign wr_data_o = user_i;
  assign rd_addr_o = scan_ptr_q;

  // Result word; the occupancy is cut or widened to the field width.
  always_comb begin
    res_o.found     = found_q;
    res_o.overflow  = over_q;
    res_o.not_empty = (count_q != '0);
    res_o.occupancy = '0;
    for (int i = 0; i < int'(rfus_pkg::OccW); i++) begin
      if (i < int'(CntW)) begin
        res_o.occupancy[i] = count_q[i];
      end
    end
  end

endmodule

// ===== hdl/request_fifo_with_user_search.sv =====
// Request queue with user-number search: stream ports and output register.
// Insert, evict and the unused code are accepted in the idle state and show their word once
// the done state hands it to the output register; no new command is taken until then.
// A search reads the memory one entry a cycle from the oldest end and ends early at the
// first match; an empty queue answers at once.
// Reset clears pointers, count and handshake state at once; the memory is not cleared.
module request_fifo_with_user_search #(
  parameter int unsigned DEPTH      = rfus_pkg::DepthDef,
  parameter int unsigned USER_WIDTH = rfus_pkg::UserWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // user_number[15:0]
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // found[0], occupancy[7:1], not_empty[8],
                                     // overflow[9], zero[15:10]
);

  localparam int unsigned PtrW = $clog2(DEPTH);

  logic [USER_WIDTH-1:0] user_w;
  logic                  res_valid;
  logic                  res_ready;
  rfus_pkg::res_t        res;
  rfus_pkg::res_t        out_q;
  logic                  out_valid_q;
  logic                  wr_en;
  logic [PtrW-1:0]       wr_addr;
  logic [USER_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [PtrW-1:0]       rd_addr;
  logic [USER_WIDTH-1:0] rd_data;

  // Fit the incoming user number to the stored width.
  always_comb begin
    user_w = '0;
    for (int i = 0; i < int'(USER_WIDTH); i++) begin
      if (i < int'(rfus_pkg::UserInW)) begin
        user_w[i] = s_axis_tdata[i];
      end
    end
  end

  rfus_ctrl #(
    .DEPTH      (DEPTH),
    .USER_WIDTH (USER_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (rfus_pkg::cmd_e'(s_axis_tuser)),
    .user_i      (user_w),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  rfus_store #(
    .DEPTH      (DEPTH),
    .USER_WIDTH (USER_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Output register: it takes a new word when empty or being drained.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q};

`ifndef SYNTHESIS
  // The memory is never written and read in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("memory written and read in the same cycle");

  // A dropped insert always comes from a non-empty queue.
  a_overflow_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[9]) |-> m_axis_tdata[8])
    else $error("overflow reported on an empty queue");

  // A result handed to the output register shows up on the port next cycle.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> m_axis_tvalid)
    else $error("result word lost at the output register");
`endif

endmodule

// ===== test/request_fifo_with_user_search_tb.sv =====
// Self-checking testbench for the request queue with user-number search.
module request_fifo_with_user_search_tb;

  localparam int unsigned Depth        = rfus_pkg::DepthDef;
  localparam int unsigned UserWidth    = rfus_pkg::UserWidthDef;
  localparam logic [rfus_pkg::CmdW-1:0] CmdUnused = 2'd3;
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = Depth + 8;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [rfus_pkg::UserInW-1:0] s_axis_tdata;   // user_number[15:0]
  logic [rfus_pkg::CmdW-1:0]    s_axis_tuser;   // command[1:0]
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [15:0]                  m_axis_tdata;   // found[0], occupancy[7:1], not_empty[8],
                                                // overflow[9], zero[15:10]

  // Software copy of the queue, used to predict each status word.
  logic [UserWidth-1:0] queued_user [Depth];
  int unsigned          queue_oldest = 0;
  int unsigned          queue_newest = 0;
  int unsigned          queue_count  = 0;
  rfus_pkg::res_t       expected_status_q [$];

  // Run statistics and shared control.
  logic [rfus_pkg::UserInW-1:0] hot_users [8];
  bit                 steady = 1'b0;
  int unsigned        hold_requests = 0;
  int unsigned        error_count = 0;
  int unsigned        word_count = 0;
  int unsigned        n_insert = 0, n_evict = 0, n_search = 0, n_unused = 0;
  int unsigned        n_hit = 0, n_dropped = 0, peak_occupancy = 0;
  int unsigned        idle_count = 0;

  request_fifo_with_user_search #(
    .DEPTH      (Depth),
    .USER_WIDTH (UserWidth)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Applies one command to the software queue and returns the status it should report.
  function automatic rfus_pkg::res_t apply_command(
    input logic [rfus_pkg::CmdW-1:0]    cmd,
    input logic [rfus_pkg::UserInW-1:0] user);
    rfus_pkg::res_t       status;
    logic [UserWidth-1:0] key;
    int unsigned          pos;
    status = '0;
    key    = user[UserWidth-1:0];
    case (cmd)
      rfus_pkg::CMD_INSERT: begin
        n_insert++;
        if (queue_count >= Depth) begin
          status.overflow = 1'b1;
          n_dropped++;
        end else begin
          queued_user[queue_newest] = key;
          queue_newest = (queue_newest + 1 == Depth) ? 0 : queue_newest + 1;
          queue_count++;
        end
      end
      rfus_pkg::CMD_EVICT: begin
        n_evict++;
        if (queue_count != 0) begin
          queue_oldest = (queue_oldest + 1 == Depth) ? 0 : queue_oldest + 1;
          queue_count--;
        end
      end
      rfus_pkg::CMD_SEARCH: begin
        n_search++;
        pos = queue_oldest;
        for (int unsigned k = 0; k < queue_count; k++) begin
          if (queued_user[pos] == key) status.found = 1'b1;
          pos = (pos + 1 == Depth) ? 0 : pos + 1;
        end
        if (status.found) n_hit++;
      end
      default: n_unused++;
    endcase
    if (queue_count > peak_occupancy) peak_occupancy = queue_count;
    status.occupancy = queue_count[rfus_pkg::OccW-1:0];
    status.not_empty = (queue_count != 0);
    return status;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // User number: a queued one, one of a few recurring ones, or anything at all.
  function automatic logic [rfus_pkg::UserInW-1:0] pick_user();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30 && queue_count != 0)
      return queued_user[(queue_oldest + $urandom_range(0, queue_count - 1)) % Depth];
    if (r < 60) return hot_users[$urandom_range(0, 7)];
    return rfus_pkg::UserInW'($urandom);
  endfunction

  // Command with the given insert and evict weights in percent; 3 percent are the unused code, the rest searches.
  function automatic logic [rfus_pkg::CmdW-1:0] pick_cmd(input int unsigned ins_w,
                                                         input int unsigned evi_w);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return CmdUnused;
    if (r < 3 + ins_w) return rfus_pkg::CMD_INSERT;
    if (r < 3 + ins_w + evi_w) return rfus_pkg::CMD_EVICT;
    return rfus_pkg::CMD_SEARCH;
  endfunction

  // Offers one request word and records its expected status once it is taken.
  task automatic push_request(input logic [rfus_pkg::CmdW-1:0]    cmd,
                              input logic [rfus_pkg::UserInW-1:0] user);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= user;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_status_q.push_back(apply_command(cmd, user));
  endtask

  // Stops offering words and waits until every expected status word has come back.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
  endtask

  // Empty-queue behaviour, both ends of the user range, hits, misses and the unused code.
  task automatic test_directed_corners();
    push_request(rfus_pkg::CMD_SEARCH, 16'h0000);
    push_request(rfus_pkg::CMD_EVICT,  16'hFFFF);
    push_request(CmdUnused,            16'hFFFF);
    push_request(rfus_pkg::CMD_INSERT, 16'h0000);
    push_request(rfus_pkg::CMD_INSERT, 16'hFFFF);
    push_request(rfus_pkg::CMD_INSERT, 16'hA5A5);
    push_request(rfus_pkg::CMD_SEARCH, 16'h0000);
    push_request(rfus_pkg::CMD_SEARCH, 16'hFFFF);
    push_request(rfus_pkg::CMD_SEARCH, 16'hA5A5);
    push_request(rfus_pkg::CMD_SEARCH, 16'h5A5A);
    push_request(CmdUnused,            16'h0000);
    push_request(rfus_pkg::CMD_EVICT,  16'h0000);
    push_request(rfus_pkg::CMD_SEARCH, 16'h0000);
    push_request(rfus_pkg::CMD_EVICT,  16'h1234);
    push_request(rfus_pkg::CMD_EVICT,  16'h1234);
    push_request(rfus_pkg::CMD_EVICT,  16'h1234);
    // The stale entry must not be found once the queue is empty again.
    push_request(rfus_pkg::CMD_SEARCH, 16'hA5A5);
    wait_drain();
  endtask

  // Fills the queue to the brim, tries to overfill it, then empties it.
  task automatic test_fill_overflow();
    while (queue_count < Depth) push_request(rfus_pkg::CMD_INSERT, pick_user());
    repeat (3) push_request(rfus_pkg::CMD_INSERT, pick_user());
    push_request(rfus_pkg::CMD_SEARCH, queued_user[queue_oldest]);
    push_request(rfus_pkg::CMD_SEARCH, queued_user[(queue_newest + Depth - 1) % Depth]);
    repeat (4) push_request(rfus_pkg::CMD_SEARCH, pick_user());
    while (queue_count != 0)
      push_request(($urandom_range(0, 3) == 0) ? rfus_pkg::CMD_SEARCH : rfus_pkg::CMD_EVICT,
                   pick_user());
    wait_drain();
  endtask

  // The receiver holds off for a long stretch while words keep arriving back to back.
  task automatic test_backpressure();
    hold_requests++;
    steady = 1'b1;
    repeat (40) push_request(pick_cmd(50, 10), pick_user());
    steady = 1'b0;
    wait_drain();
  endtask

  // Phases of random commands whose mix pushes the occupancy up, down and around.
  task automatic test_random_mix();
    int unsigned ins_w;
    int unsigned evi_w;
    for (int phase = 0; phase < 14; phase++) begin
      case (phase % 4)
        0:       begin ins_w = 60; evi_w = 15; end
        1:       begin ins_w = 30; evi_w = 30; end
        2:       begin ins_w = 15; evi_w = 60; end
        default: begin ins_w = 45; evi_w = 20; end
      endcase
      steady = (phase == 5);
      repeat (55) push_request(pick_cmd(ins_w, evi_w), pick_user());
    end
    steady = 1'b0;
    wait_drain();
  endtask

  // Receiver ready: random stalls, plus the long hold when one is requested.
  initial begin : drive_ready
    int unsigned stall;
    int unsigned holds_served;
    stall        = 0;
    holds_served = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        stall = HoldCycles;
      end else if (stall == 0 && !steady && $urandom_range(0, 99) < 30) begin
        stall = pick_gap();
      end
      m_axis_tready <= (stall == 0);
      if (stall != 0) stall--;
    end
  end

  // Compares every status word taken from the block with the oldest expectation.
  always @(posedge clk_i) begin : check_status
    rfus_pkg::res_t got;
    rfus_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = rfus_pkg::res_t'(m_axis_tdata[9:0]);
      word_count++;
      if (expected_status_q.size() == 0) begin
        $display("%0t: status word %h arrived with nothing expected", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = expected_status_q.pop_front();
        if (got.found !== want.found || got.occupancy !== want.occupancy ||
            got.not_empty !== want.not_empty || got.overflow !== want.overflow ||
            m_axis_tdata[15:10] !== 6'd0) begin
          $display("%0t: status mismatch: expected found=%0b occ=%0d not_empty=%0b ovf=%0b pad=0",
                   $time, want.found, want.occupancy, want.not_empty, want.overflow);
          $display("%0t:                  actual   found=%0b occ=%0d not_empty=%0b ovf=%0b pad=%h",
                   $time, got.found, got.occupancy, got.not_empty, got.overflow,
                   m_axis_tdata[15:10]);
          error_count++;
        end
      end
    end
  end

  // Ends the run if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_count <= 0;
    end else if (idle_count >= IdleLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
      $display("FAIL request_fifo_with_user_search");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin : run_tests
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    hot_users[0] = '0;
    hot_users[1] = '1;
    for (int k = 2; k < 8; k++) hot_users[k] = rfus_pkg::UserInW'($urandom);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_fill_overflow();
    test_backpressure();
    test_random_mix();

    // Let any stray word show itself before the verdict.
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d commands: %0d inserts, %0d evicts, %0d searches, %0d unused codes.",
             n_insert + n_evict + n_search + n_unused, n_insert, n_evict, n_search, n_unused);
    $display("Checked %0d status words; %0d search hits, %0d dropped inserts, peak %0d of %0d.",
             word_count, n_hit, n_dropped, peak_occupancy, Depth);
    if (error_count == 0 && expected_status_q.size() == 0) begin
      $display("PASS request_fifo_with_user_search");
    end else begin
      $display("FAIL request_fifo_with_user_search");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rfus_pkg.sv
hdl/rfus_store.sv
hdl/rfus_ctrl.sv
hdl/request_fifo_with_user_search.sv
test/request_fifo_with_user_search_tb.sv
